/* hdl/sdc_pkg.sv */
// Shared constants, codes and types of the stack discipline classifier.
// Depends on nothing; sdc_cell, sdc_stack and the top level import it.
package sdc_pkg;

	localparam int MAX_CELLS = 64;
	localparam int MAX_READS = 256;
	localparam int IDX_W     = 6;
	localparam int CELL_AW   = $clog2(MAX_CELLS);
	localparam int READ_AW   = $clog2(MAX_READS);
	localparam int CCNT_W    = $clog2(MAX_CELLS + 1);
	localparam int RCNT_W    = $clog2(MAX_READS + 1);
	localparam int CMP_W     = 8;

	localparam logic [1:0] KIND_CELL = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_RUN  = 2'd2;
	localparam logic [1:0] TYPE_LEAF = 2'd0;
	localparam logic [1:0] TYPE_ASM  = 2'd1;

	// Stack row commands; STK_IDLE also moves a hole one cell toward the bottom
	typedef enum logic [2:0] {
		STK_IDLE,
		STK_CLEAR,
		STK_PUSH,
		STK_POP,
		STK_REMOVE
	} stk_op_t;

	typedef struct packed {
		stk_op_t          op;
		logic [IDX_W-1:0] data;
	} stk_cmd_t;

	typedef struct packed {
		logic top_hit;
		logic busy;
		logic full;
	} stk_stat_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_P1_RD,
		S_P1_USE,
		S_P1_NOTE,
		S_A_RD,
		S_A_USE,
		S_A_NOTE,
		S_W_CELL,
		S_W_CUSE,
		S_W_RRD,
		S_W_RUSE,
		S_W_RCHK,
		S_W_RNEXT,
		S_W_ASM,
		S_W_ACHK,
		S_CLOSE,
		S_COMPACT,
		S_W_PUSH,
		S_OUT
	} sdc_state_t;

endpackage

/* hdl/sdc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module sdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/sdc_cell.sv */
// One cell of the live stack row: one entry and its valid bit.
// Depends on sdc_pkg.
module sdc_cell import sdc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  stk_cmd_t         cmd,
	input  logic             lft_v,
	input  logic [IDX_W-1:0] lft_d,
	input  logic             rgt_v,
	input  logic [IDX_W-1:0] rgt_d,
	output logic             v,
	output logic [IDX_W-1:0] d,
	output logic             hit
);

	logic             v_q, v_n;
	logic [IDX_W-1:0] d_q, d_n;

	assign v   = v_q;
	assign d   = d_q;
	assign hit = v_q && (d_q == cmd.data);

	// next entry: clear, shift toward top or bottom, drop on match, close holes
	always_comb begin
		v_n = v_q;
		d_n = d_q;
		unique case (cmd.op)
			STK_CLEAR: begin
				v_n = 1'b0;
			end
			STK_PUSH: begin
				v_n = lft_v;
				d_n = lft_d;
			end
			STK_POP: begin
				v_n = rgt_v;
				d_n = rgt_d;
			end
			STK_REMOVE: begin
				if (hit) v_n = 1'b0;
			end
			STK_IDLE: begin
				if (!v_q && rgt_v) begin
					v_n = 1'b1;
					d_n = rgt_d;
				end else if (v_q && !lft_v) begin
					v_n = 1'b0;
				end
			end
			default: begin
				v_n = v_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_n;
		end
	end

	always_ff @(posedge clk) begin
		d_q <= d_n;
	end

endmodule

/* hdl/sdc_stack.sv */
// Live stack as a row of cells, top at cell zero, plus its status flags.
// Depends on sdc_pkg and sdc_cell.
module sdc_stack import sdc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  stk_cmd_t  cmd,
	output stk_stat_t stat
);

	logic [MAX_CELLS-1:0] v_w;
	logic [IDX_W-1:0]     d_w [MAX_CELLS];
	logic [MAX_CELLS-1:0] hit_w;
	logic [MAX_CELLS-1:0] hole_w;

	// row of cells; cell zero sees the push word on its left
	for (genvar i = 0; i < MAX_CELLS; i++) begin : g_cell
		logic             lv, rv;
		logic [IDX_W-1:0] ld, rd;
		if (i == 0) begin : g_first
			assign lv = 1'b1;
			assign ld = cmd.data;
		end else begin : g_mid
			assign lv = v_w[i-1];
			assign ld = d_w[i-1];
		end
		if (i == MAX_CELLS - 1) begin : g_last
			assign rv        = 1'b0;
			assign rd        = '0;
			assign hole_w[i] = 1'b0;
		end else begin : g_inner
			assign rv        = v_w[i+1];
			assign rd        = d_w[i+1];
			assign hole_w[i] = !v_w[i] && v_w[i+1];
		end
		sdc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.lft_v  (lv),
			.lft_d  (ld),
			.rgt_v  (rv),
			.rgt_d  (rd),
			.v      (v_w[i]),
			.d      (d_w[i]),
			.hit    (hit_w[i])
		);
	end

	// status: top match, a hole still moving down, row full
	assign stat.top_hit = hit_w[0];
	assign stat.busy    = |hole_w;
	assign stat.full    = v_w[MAX_CELLS-1];

endmodule

/* hdl/stack_discipline_classifier.sv */
// Top level of the stack discipline classifier: loader, pass sequencer,
// result channel. Depends on sdc_pkg, sdc_ram and sdc_stack.
//
// Usage: the request channel (req_valid / req_stall) takes one word per
// cycle while the block is idle: cell words and read words are stored in
// arrival order. A run word starts the analysis if any cell word is
// stored; req_stall stays high until the last result has entered the
// output register. A run with N cells first scans the read list and the
// cell list, then walks the cells; a close that removes from inside the
// stack waits while the hole travels down the stack row. The read list
// is rescanned from its RAM for every non-leaf cell; that scan sets the
// run time. Then N results follow, one per cycle while the receiver does
// not stall, in cell order.
// The response channel (rsp_valid / rsp_stall) is one output register; while
// the receiver stalls, the result holds and the walk of results waits.
// Reset clears the tables' counts, the error flag, the stack row and the
// flags; table RAM contents are not cleared and need none. After a run the
// counts and the error flag return to zero for the next table.
module stack_discipline_classifier import sdc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic [1:0]       kind,
	input  logic [1:0]       cell_type,
	input  logic [IDX_W-1:0] assemble_source,
	input  logic [IDX_W-1:0] read_source,
	input  logic [IDX_W-1:0] read_consumer,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic [IDX_W-1:0] cell_index,
	output logic             random_access,
	output logic             bad_index,
	output logic             last_of_run
);

	sdc_state_t state_q, state_d;

	logic [CCNT_W-1:0]    ccnt_q, n_q, id_q, oi_q;
	logic [RCNT_W-1:0]    rcnt_q, r_q;
	logic                 err_q, bad_q, ret_asm_q;
	logic [IDX_W-1:0]     src_q, con_q, asrc_id_q;
	logic [1:0]           typ_id_q;
	logic [MAX_CELLS-1:0] luv_q, flag_q;

	logic                 rsp_valid_q, random_access_q, bad_index_q, last_of_run_q;
	logic [IDX_W-1:0]     cell_index_q;

	logic                 acc;
	logic                 cram_we, rram_we, lu_we;
	logic [CELL_AW-1:0]   cram_ra, lu_ra;
	logic [READ_AW-1:0]   rram_ra;
	logic [7:0]           cram_rd;
	logic [11:0]          rram_rd;
	logic [IDX_W-1:0]     lu_rd;
	stk_cmd_t             stk_cmd;
	stk_stat_t            stk_stat;

	logic [IDX_W-1:0]     rd_src, rd_con, c_asrc;
	logic [1:0]           c_type;
	logic                 rd_src_oor, rd_con_oor, c_asrc_oor, asrc_id_ok;
	logic                 ends, note_wr, r_last, id_last, o_take, o_last;
	logic [CELL_AW-1:0]   src_cell;

	assign acc       = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);

	assign cram_we = acc && (kind == KIND_CELL) && (ccnt_q < CCNT_W'(MAX_CELLS));
	assign rram_we = acc && (kind == KIND_READ) && (rcnt_q < RCNT_W'(MAX_READS));

	// table memories and last-consumer store
	sdc_ram #(.WIDTH(8), .DEPTH(MAX_CELLS)) u_cram (
		.clk   (clk),
		.we    (cram_we),
		.waddr (ccnt_q[CELL_AW-1:0]),
		.wdata ({cell_type, assemble_source}),
		.raddr (cram_ra),
		.rdata (cram_rd)
	);

	sdc_ram #(.WIDTH(12), .DEPTH(MAX_READS)) u_rram (
		.clk   (clk),
		.we    (rram_we),
		.waddr (rcnt_q[READ_AW-1:0]),
		.wdata ({read_source, read_consumer}),
		.raddr (rram_ra),
		.rdata (rram_rd)
	);

	sdc_ram #(.WIDTH(IDX_W), .DEPTH(MAX_CELLS)) u_luram (
		.clk   (clk),
		.we    (lu_we),
		.waddr (src_cell),
		.wdata (con_q),
		.raddr (lu_ra),
		.rdata (lu_rd)
	);

	sdc_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (stk_cmd),
		.stat   (stk_stat)
	);

	// decode of fetched words and shared compares
	assign rd_src     = rram_rd[11:6];
	assign rd_con     = rram_rd[5:0];
	assign c_type     = cram_rd[7:6];
	assign c_asrc     = cram_rd[5:0];
	assign rd_src_oor = CMP_W'(rd_src) >= CMP_W'(n_q);
	assign rd_con_oor = CMP_W'(rd_con) >= CMP_W'(n_q);
	assign c_asrc_oor = CMP_W'(c_asrc) >= CMP_W'(n_q);
	assign asrc_id_ok = (typ_id_q == TYPE_ASM) && (CMP_W'(asrc_id_q) < CMP_W'(n_q));
	assign src_cell   = src_q[CELL_AW-1:0];
	assign ends       = luv_q[src_cell] && (CMP_W'(lu_rd) == CMP_W'(id_q));
	assign note_wr    = !luv_q[src_cell] || (con_q > lu_rd);
	assign r_last     = (r_q + RCNT_W'(1)) == rcnt_q;
	assign id_last    = (id_q + CCNT_W'(1)) == n_q;
	assign o_take     = !rsp_valid_q || !rsp_stall;
	assign o_last     = (oi_q + CCNT_W'(1)) == n_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && (kind == KIND_RUN) && (ccnt_q != '0)) begin
					state_d = (rcnt_q == '0) ? S_A_RD : S_P1_RD;
				end
			end
			S_P1_RD:   state_d = S_P1_USE;
			S_P1_USE: begin
				if (!rd_src_oor) state_d = S_P1_NOTE;
				else             state_d = r_last ? S_A_RD : S_P1_RD;
			end
			S_P1_NOTE: state_d = r_last ? S_A_RD : S_P1_RD;
			S_A_RD:    state_d = S_A_USE;
			S_A_USE: begin
				if ((c_type == TYPE_ASM) && !c_asrc_oor) state_d = S_A_NOTE;
				else                                      state_d = id_last ? S_W_CELL : S_A_RD;
			end
			S_A_NOTE:  state_d = id_last ? S_W_CELL : S_A_RD;
			S_W_CELL:  state_d = S_W_CUSE;
			S_W_CUSE: begin
				if (c_type == TYPE_LEAF)  state_d = id_last ? S_OUT : S_W_CELL;
				else if (rcnt_q == '0)    state_d = S_W_ASM;
				else                      state_d = S_W_RRD;
			end
			S_W_RRD:   state_d = S_W_RUSE;
			S_W_RUSE: begin
				if ((CMP_W'(rd_con) != CMP_W'(id_q)) || rd_src_oor) state_d = S_W_RNEXT;
				else                                                state_d = S_W_RCHK;
			end
			S_W_RCHK: begin
				if ((c_type != TYPE_LEAF) && ends) state_d = S_CLOSE;
				else                               state_d = S_W_RNEXT;
			end
			S_W_RNEXT: state_d = r_last ? S_W_ASM : S_W_RRD;
			S_W_ASM:   state_d = asrc_id_ok ? S_W_ACHK : S_W_PUSH;
			S_W_ACHK:  state_d = ends ? S_CLOSE : S_W_PUSH;
			S_CLOSE: begin
				if (!stk_stat.top_hit) state_d = S_COMPACT;
				else                   state_d = ret_asm_q ? S_W_PUSH : S_W_RNEXT;
			end
			S_COMPACT: begin
				if (!stk_stat.busy) state_d = ret_asm_q ? S_W_PUSH : S_W_RNEXT;
			end
			S_W_PUSH:  state_d = id_last ? S_OUT : S_W_CELL;
			S_OUT: begin
				if (o_take && o_last) state_d = S_IDLE;
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// memory addresses, store writes and stack commands
	always_comb begin
		cram_ra      = id_q[CELL_AW-1:0];
		rram_ra      = r_q[READ_AW-1:0];
		lu_ra        = rd_src[CELL_AW-1:0];
		lu_we        = 1'b0;
		stk_cmd.op   = STK_IDLE;
		stk_cmd.data = src_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && (kind == KIND_RUN)) stk_cmd.op = STK_CLEAR;
			end
			S_A_USE: begin
				lu_ra = c_asrc[CELL_AW-1:0];
			end
			S_P1_NOTE, S_A_NOTE: begin
				lu_we = note_wr;
			end
			S_W_RUSE: begin
				cram_ra = rd_src[CELL_AW-1:0];
			end
			S_W_ASM: begin
				lu_ra = asrc_id_q[CELL_AW-1:0];
			end
			S_CLOSE: begin
				stk_cmd.op = stk_stat.top_hit ? STK_POP : STK_REMOVE;
			end
			S_W_PUSH: begin
				stk_cmd.data = IDX_W'(id_q);
				if (!stk_stat.full) stk_cmd.op = STK_PUSH;
			end
			default: begin
				lu_we = 1'b0;
			end
		endcase
	end

	// sequencer registers, counters and per-cell bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ccnt_q    <= '0;
			rcnt_q    <= '0;
			err_q     <= 1'b0;
			n_q       <= '0;
			bad_q     <= 1'b0;
			r_q       <= '0;
			id_q      <= '0;
			oi_q      <= '0;
			ret_asm_q <= 1'b0;
			src_q     <= '0;
			con_q     <= '0;
			typ_id_q  <= '0;
			asrc_id_q <= '0;
			luv_q     <= '0;
			flag_q    <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (kind == KIND_CELL) begin
							if (cram_we) ccnt_q <= ccnt_q + CCNT_W'(1);
							else         err_q  <= 1'b1;
						end else if (kind == KIND_READ) begin
							if (rram_we) rcnt_q <= rcnt_q + RCNT_W'(1);
							else         err_q  <= 1'b1;
						end else if (kind == KIND_RUN) begin
							n_q    <= ccnt_q;
							bad_q  <= err_q;
							luv_q  <= '0;
							flag_q <= '0;
							r_q    <= '0;
							id_q   <= '0;
							oi_q   <= '0;
							if (ccnt_q == '0) begin
								rcnt_q <= '0;
								err_q  <= 1'b0;
							end
						end
					end
				end
				S_P1_USE: begin
					src_q <= rd_src;
					con_q <= rd_con;
					if (rd_src_oor || rd_con_oor) bad_q <= 1'b1;
					if (rd_src_oor) r_q <= r_q + RCNT_W'(1);
				end
				S_P1_NOTE: begin
					if (note_wr) luv_q[src_cell] <= 1'b1;
					r_q <= r_q + RCNT_W'(1);
				end
				S_A_USE: begin
					src_q <= c_asrc;
					con_q <= IDX_W'(id_q);
					if ((c_type == TYPE_ASM) && c_asrc_oor) bad_q <= 1'b1;
					if (!((c_type == TYPE_ASM) && !c_asrc_oor)) begin
						id_q <= id_last ? '0 : id_q + CCNT_W'(1);
					end
				end
				S_A_NOTE: begin
					if (note_wr) luv_q[src_cell] <= 1'b1;
					id_q <= id_last ? '0 : id_q + CCNT_W'(1);
				end
				S_W_CUSE: begin
					typ_id_q  <= c_type;
					asrc_id_q <= c_asrc;
					r_q       <= '0;
					if (c_type == TYPE_LEAF) id_q <= id_q + CCNT_W'(1);
				end
				S_W_RUSE: begin
					src_q     <= rd_src;
					ret_asm_q <= 1'b0;
				end
				S_W_RNEXT: begin
					r_q <= r_q + RCNT_W'(1);
				end
				S_W_ASM: begin
					src_q     <= asrc_id_q;
					ret_asm_q <= 1'b1;
				end
				S_CLOSE: begin
					if (!stk_stat.top_hit) flag_q[src_cell] <= 1'b1;
				end
				S_W_PUSH: begin
					id_q <= id_q + CCNT_W'(1);
				end
				S_OUT: begin
					if (o_take) begin
						oi_q <= oi_q + CCNT_W'(1);
						if (o_last) begin
							ccnt_q <= '0;
							rcnt_q <= '0;
							err_q  <= 1'b0;
						end
					end
				end
				default: begin
					bad_q <= bad_q;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (o_take) begin
			rsp_valid_q <= (state_q == S_OUT);
		end
	end

	always_ff @(posedge clk) begin
		if (o_take && (state_q == S_OUT)) begin
			cell_index_q    <= IDX_W'(oi_q);
			random_access_q <= flag_q[oi_q[CELL_AW-1:0]];
			bad_index_q     <= bad_q;
			last_of_run_q   <= o_last;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign cell_index    = cell_index_q;
	assign random_access = random_access_q;
	assign bad_index     = bad_index_q;
	assign last_of_run   = last_of_run_q;

endmodule
